[hdl/fee_pkg.sv]
// ----------------------------------------------------------------------------
// fee_pkg
// Shared types and constants of the fuzzy energy budget estimator: widths,
// register map, membership cases and the records passed between stages.
// ----------------------------------------------------------------------------
package fee_pkg;

    // Q1.16 value of a full membership
    localparam logic [16:0] MU_ONE = 17'h10000;

    // Quotient bits of a ramp division and of the budget division
    localparam int RAMP_BITS  = 17;
    localparam int QUOT_BITS  = 40;
    localparam int RULE_COUNT = 6;

    // Configuration port
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // Register reset values
    localparam logic [31:0] EMPTY_THR_RST = 32'h0001_0000;
    localparam logic [31:0] FULL_THR_RST  = 32'h0002_0000;
    localparam logic [31:0] NEG_THR_RST   = 32'hFFFF_0000;
    localparam logic [30:0] POS_THR_RST   = 31'h0001_0000;
    localparam logic [47:0] COEF_RST      = 48'h0605_0403_0201;

    // Register indexes (byte address / 8)
    typedef enum logic [2:0] {
        REG_EMPTY_THR = 3'd0,
        REG_FULL_THR  = 3'd1,
        REG_NEG_THR   = 3'd2,
        REG_POS_THR   = 3'd3,
        REG_COEF      = 3'd4
    } fee_reg_t;

    // Where the energy falls relative to its thresholds
    typedef enum logic [1:0] {
        E_EMPTY,
        E_RAMP,
        E_FULL
    } fee_ecase_t;

    // Where the change falls relative to its thresholds
    typedef enum logic [1:0] {
        C_NEG,
        C_NRAMP,
        C_PRAMP,
        C_POS
    } fee_ccase_t;

    // Memberships of one request, out of the fuzzifier
    typedef struct packed {
        logic        valid;
        logic [31:0] er;
        logic [16:0] emp;
        logic [16:0] ful;
        logic [16:0] neg;
        logic [16:0] zer;
        logic [16:0] pos;
    } fee_memb_t;

    // Dividend and divisor of one request, out of the rule stage
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic [16:0] asum;
        logic [55:0] prod;
    } fee_prod_t;

endpackage

[hdl/fee_fuzz.sv]
// ----------------------------------------------------------------------------
// fee_fuzz
// Fuzzifier: classifies energy and change against the thresholds, runs the
// three ramp divisions one quotient bit per stage and selects memberships.
// ----------------------------------------------------------------------------
module fee_fuzz
    import fee_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             take,
    input  logic [31:0]      residual_energy,
    input  logic [31:0]      energy_change,
    input  logic [31:0]      empty_thr,
    input  logic [31:0]      full_lvl,
    input  logic [31:0]      neg_thr,
    input  logic [30:0]      pos_thr,
    output fee_memb_t        memb
);

    // Stage 0 classification
    fee_ecase_t  ecase_next;
    fee_ccase_t  ccase_next;
    logic [31:0] e_num_next;
    logic [31:0] f_num_next;
    logic [31:0] e_den_next;
    logic [31:0] c_num_next;
    logic [31:0] c_den_next;
    logic signed [31:0] d_s;
    logic signed [31:0] n_s;
    logic signed [31:0] p_s;

    logic        v0_reg;
    fee_ecase_t  ecase0_reg;
    fee_ccase_t  ccase0_reg;
    logic [31:0] er0_reg;
    logic [31:0] e_num0_reg;
    logic [31:0] f_num0_reg;
    logic [31:0] e_den0_reg;
    logic [31:0] c_num0_reg;
    logic [31:0] c_den0_reg;

    // Division stages
    logic              v_reg     [1:RAMP_BITS];
    fee_ecase_t        ecase_reg [1:RAMP_BITS];
    fee_ccase_t        ccase_reg [1:RAMP_BITS];
    logic [31:0]       er_reg    [1:RAMP_BITS];
    logic [31:0]       e_den_reg [1:RAMP_BITS];
    logic [31:0]       c_den_reg [1:RAMP_BITS];
    logic [32:0]       e_rem_reg [1:RAMP_BITS];
    logic [32:0]       f_rem_reg [1:RAMP_BITS];
    logic [32:0]       c_rem_reg [1:RAMP_BITS];
    logic [16:0]       e_q_reg   [1:RAMP_BITS];
    logic [16:0]       f_q_reg   [1:RAMP_BITS];
    logic [16:0]       c_q_reg   [1:RAMP_BITS];

    // Membership output stage
    fee_memb_t   memb_next;
    logic        memb_valid_reg;
    logic [31:0] memb_er_reg;
    logic [16:0] memb_emp_reg;
    logic [16:0] memb_ful_reg;
    logic [16:0] memb_neg_reg;
    logic [16:0] memb_zer_reg;
    logic [16:0] memb_pos_reg;

    // Classify energy and change, form ramp numerators and spans
    always_comb
    begin
        d_s = $signed(energy_change);
        n_s = $signed(neg_thr);
        p_s = $signed({1'b0, pos_thr});

        if (residual_energy < empty_thr)
            ecase_next = E_EMPTY;
        else if (residual_energy < full_lvl)
            ecase_next = E_RAMP;
        else
            ecase_next = E_FULL;

        e_num_next = full_lvl - residual_energy;
        f_num_next = residual_energy - empty_thr;
        e_den_next = full_lvl - empty_thr;

        if (d_s < n_s)
            ccase_next = C_NEG;
        else if (d_s < 32'sd0)
            ccase_next = C_NRAMP;
        else if (d_s < p_s)
            ccase_next = C_PRAMP;
        else
            ccase_next = C_POS;

        if (energy_change[31])
        begin
            c_num_next = ~energy_change + 32'd1;
            c_den_next = ~neg_thr + 32'd1;
        end
        else
        begin
            c_num_next = energy_change;
            c_den_next = {1'b0, pos_thr};
        end
    end

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ecase0_reg <= ecase_next;
            ccase0_reg <= ccase_next;
            er0_reg    <= residual_energy;
            e_num0_reg <= e_num_next;
            f_num0_reg <= f_num_next;
            e_den0_reg <= e_den_next;
            c_num0_reg <= c_num_next;
            c_den0_reg <= c_den_next;
        end
    end

    // One restoring step per stage on each of the three divisions
    for (genvar k = 1; k <= RAMP_BITS; k++)
    begin : g_step
        logic        src_v;
        fee_ecase_t  src_ecase;
        fee_ccase_t  src_ccase;
        logic [31:0] src_er;
        logic [31:0] src_e_den;
        logic [31:0] src_c_den;
        logic [32:0] src_e_rem;
        logic [32:0] src_f_rem;
        logic [32:0] src_c_rem;
        logic [16:0] src_e_q;
        logic [16:0] src_f_q;
        logic [16:0] src_c_q;
        logic        e_ge;
        logic        f_ge;
        logic        c_ge;
        logic [32:0] e_sub;
        logic [32:0] f_sub;
        logic [32:0] c_sub;

        if (k == 1)
        begin : g_first
            assign src_v     = v0_reg;
            assign src_ecase = ecase0_reg;
            assign src_ccase = ccase0_reg;
            assign src_er    = er0_reg;
            assign src_e_den = e_den0_reg;
            assign src_c_den = c_den0_reg;
            assign src_e_rem = {1'b0, e_num0_reg};
            assign src_f_rem = {1'b0, f_num0_reg};
            assign src_c_rem = {1'b0, c_num0_reg};
            assign src_e_q   = '0;
            assign src_f_q   = '0;
            assign src_c_q   = '0;
        end
        else
        begin : g_next
            assign src_v     = v_reg[k-1];
            assign src_ecase = ecase_reg[k-1];
            assign src_ccase = ccase_reg[k-1];
            assign src_er    = er_reg[k-1];
            assign src_e_den = e_den_reg[k-1];
            assign src_c_den = c_den_reg[k-1];
            assign src_e_rem = e_rem_reg[k-1];
            assign src_f_rem = f_rem_reg[k-1];
            assign src_c_rem = c_rem_reg[k-1];
            assign src_e_q   = e_q_reg[k-1];
            assign src_f_q   = f_q_reg[k-1];
            assign src_c_q   = c_q_reg[k-1];
        end

        always_comb
        begin
            e_ge  = src_e_rem >= {1'b0, src_e_den};
            f_ge  = src_f_rem >= {1'b0, src_e_den};
            c_ge  = src_c_rem >= {1'b0, src_c_den};
            e_sub = e_ge ? src_e_rem - {1'b0, src_e_den} : src_e_rem;
            f_sub = f_ge ? src_f_rem - {1'b0, src_e_den} : src_f_rem;
            c_sub = c_ge ? src_c_rem - {1'b0, src_c_den} : src_c_rem;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ecase_reg[k] <= src_ecase;
                ccase_reg[k] <= src_ccase;
                er_reg[k]    <= src_er;
                e_den_reg[k] <= src_e_den;
                c_den_reg[k] <= src_c_den;
                e_rem_reg[k] <= {e_sub[31:0], 1'b0};
                f_rem_reg[k] <= {f_sub[31:0], 1'b0};
                c_rem_reg[k] <= {c_sub[31:0], 1'b0};
                e_q_reg[k]   <= {src_e_q[15:0], e_ge};
                f_q_reg[k]   <= {src_f_q[15:0], f_ge};
                c_q_reg[k]   <= {src_c_q[15:0], c_ge};
            end
        end
    end

    // Pick each membership from its case and quotient
    always_comb
    begin
        memb_next       = '0;
        memb_next.valid = v_reg[RAMP_BITS];
        memb_next.er    = er_reg[RAMP_BITS];

        case (ecase_reg[RAMP_BITS])
            E_EMPTY:
            begin
                memb_next.emp = MU_ONE;
            end
            E_RAMP:
            begin
                memb_next.emp = e_q_reg[RAMP_BITS];
                memb_next.ful = f_q_reg[RAMP_BITS];
            end
            default:
            begin
                memb_next.ful = MU_ONE;
            end
        endcase

        case (ccase_reg[RAMP_BITS])
            C_NEG:
            begin
                memb_next.neg = MU_ONE;
            end
            C_NRAMP:
            begin
                memb_next.neg = c_q_reg[RAMP_BITS];
                memb_next.zer = MU_ONE - c_q_reg[RAMP_BITS];
            end
            C_PRAMP:
            begin
                memb_next.pos = c_q_reg[RAMP_BITS];
                memb_next.zer = MU_ONE - c_q_reg[RAMP_BITS];
            end
            default:
            begin
                memb_next.pos = MU_ONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            memb_valid_reg <= 1'b0;
        else if (adv)
            memb_valid_reg <= memb_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            memb_er_reg  <= memb_next.er;
            memb_emp_reg <= memb_next.emp;
            memb_ful_reg <= memb_next.ful;
            memb_neg_reg <= memb_next.neg;
            memb_zer_reg <= memb_next.zer;
            memb_pos_reg <= memb_next.pos;
        end
    end

    assign memb = {memb_valid_reg, memb_er_reg, memb_emp_reg, memb_ful_reg,
                   memb_neg_reg, memb_zer_reg, memb_pos_reg};

endmodule

[hdl/fee_rules.sv]
// ----------------------------------------------------------------------------
// fee_rules
// Rule stage: forms the six activations, weights them by the coefficients,
// sums weights and activations and scales the weighted sum by the energy.
// ----------------------------------------------------------------------------
module fee_rules
    import fee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  fee_memb_t   memb,
    input  logic [47:0] coef,
    output fee_prod_t   prod
);

    logic [16:0] me [0:1];
    logic [16:0] md [0:2];
    logic [33:0] act_full [0:RULE_COUNT-1];

    // Stage A: activations
    logic        va_reg;
    logic [31:0] era_reg;
    logic [16:0] act_reg [0:RULE_COUNT-1];

    // Stage B: weighted activations and activation sum
    logic        vb_reg;
    logic [31:0] erb_reg;
    logic [24:0] wprod_reg [0:RULE_COUNT-1];
    logic [16:0] asumb_reg;
    logic [19:0] asum_wide;

    // Stage C: weighted sum
    logic        vc_reg;
    logic [31:0] erc_reg;
    logic [16:0] asumc_reg;
    logic [23:0] wsum_reg;
    logic [27:0] wsum_wide;

    // Output stage
    logic        prod_valid_reg;
    logic        prod_zero_reg;
    logic [16:0] prod_asum_reg;
    logic [55:0] prod_val_reg;

    always_comb
    begin
        me[0] = memb.emp;
        me[1] = memb.ful;
        md[0] = memb.neg;
        md[1] = memb.zer;
        md[2] = memb.pos;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                act_full[i*3 + j] = me[i] * md[j];
            end
        end
    end

    // Sum of activations and of weighted activations
    always_comb
    begin
        asum_wide = '0;
        for (int k = 0; k < RULE_COUNT; k++)
        begin
            asum_wide = asum_wide + {3'b000, act_reg[k]};
        end
        wsum_wide = '0;
        for (int k = 0; k < RULE_COUNT; k++)
        begin
            wsum_wide = wsum_wide + {3'b000, wprod_reg[k]};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg         <= memb.valid;
            vb_reg         <= va_reg;
            vc_reg         <= vb_reg;
            prod_valid_reg <= vc_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            era_reg <= memb.er;
            for (int k = 0; k < RULE_COUNT; k++)
            begin
                act_reg[k]   <= act_full[k][32:16];
                wprod_reg[k] <= act_reg[k] * coef[8*k +: 8];
            end
            erb_reg       <= era_reg;
            asumb_reg     <= asum_wide[16:0];
            erc_reg       <= erb_reg;
            asumc_reg     <= asumb_reg;
            wsum_reg      <= wsum_wide[23:0];
            prod_val_reg  <= wsum_reg * erc_reg;
            prod_asum_reg <= asumc_reg;
            prod_zero_reg <= (asumc_reg == '0);
        end
    end

    assign prod = {prod_valid_reg, prod_zero_reg, prod_asum_reg, prod_val_reg};

endmodule

[hdl/fee_div.sv]
// ----------------------------------------------------------------------------
// fee_div
// Budget divider: restoring division of the scaled weighted sum by the
// activation sum, one quotient bit per stage, then the output register.
// ----------------------------------------------------------------------------
module fee_div
    import fee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  fee_prod_t   prod,
    output logic        out_valid,
    output logic [39:0] energy_budget
);

    logic        v_reg    [1:QUOT_BITS];
    logic        zero_reg [1:QUOT_BITS];
    logic [16:0] den_reg  [1:QUOT_BITS];
    logic [16:0] rem_reg  [1:QUOT_BITS];
    logic [39:0] lq_reg   [1:QUOT_BITS];

    logic        out_valid_reg;
    logic [39:0] budget_reg;

    // One quotient bit per stage; dividend bits shift out as quotient shifts in
    for (genvar k = 1; k <= QUOT_BITS; k++)
    begin : g_step
        logic        src_v;
        logic        src_zero;
        logic [16:0] src_den;
        logic [16:0] src_rem;
        logic [39:0] src_lq;
        logic [17:0] trial;
        logic [17:0] diff;
        logic        ge;

        if (k == 1)
        begin : g_first
            assign src_v    = prod.valid;
            assign src_zero = prod.zero;
            assign src_den  = prod.asum;
            assign src_rem  = {1'b0, prod.prod[55:40]};
            assign src_lq   = prod.prod[39:0];
        end
        else
        begin : g_next
            assign src_v    = v_reg[k-1];
            assign src_zero = zero_reg[k-1];
            assign src_den  = den_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_lq   = lq_reg[k-1];
        end

        always_comb
        begin
            trial = {src_rem, src_lq[39]};
            ge    = trial >= {1'b0, src_den};
            diff  = ge ? trial - {1'b0, src_den} : trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                zero_reg[k] <= src_zero;
                den_reg[k]  <= src_den;
                rem_reg[k]  <= diff[16:0];
                lq_reg[k]   <= {src_lq[38:0], ge};
            end
        end
    end

    // Hold the result until taken; zero activation sum gives zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[QUOT_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            budget_reg <= zero_reg[QUOT_BITS] ? '0 : lq_reg[QUOT_BITS];
    end

    assign out_valid     = out_valid_reg;
    assign energy_budget = budget_reg;

endmodule

[hdl/fuzzy_energy_budget_estimator_core.sv]
// ----------------------------------------------------------------------------
// fuzzy_energy_budget_estimator_core
// Energy budget from residual energy and its change by zero-order fuzzy
// inference; pipelined, one request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries residual_energy (unsigned
//   Q16.16) and energy_change (signed Q16.16). Output channel (out_valid /
//   out_stall) carries energy_budget (unsigned Q24.16). A request moves when
//   valid is high and stall is low at a rising clock edge.
//   A request passes one classify stage, 17 ramp-division stages,
//   membership select, four rule stages, 40 budget-division stages and
//   the output register. Throughput is one request per cycle unless
//   stalled; the two pipelined dividers set the depth.
//   When the receiver stalls a held result, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the default thresholds and rule
//   coefficients. Write the registers over the APB port only while idle.
// ----------------------------------------------------------------------------
module fuzzy_energy_budget_estimator_core
    import fee_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         residual_energy,
    input  logic signed [31:0]  energy_change,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [39:0]         energy_budget,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [31:0] empty_thr_reg;
    logic [31:0] full_lvl_reg;
    logic [31:0] neg_thr_reg;
    logic [30:0] pos_thr_reg;
    logic [47:0] coef_reg;

    logic      adv;
    logic      take;
    logic      wr_en;
    fee_reg_t  reg_idx;
    fee_memb_t memb;
    fee_prod_t prod;

    // Freeze everything while a held result is stalled
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign take     = in_valid && adv;

    // Register writes
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = fee_reg_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_thr_reg <= EMPTY_THR_RST;
            full_lvl_reg  <= FULL_THR_RST;
            neg_thr_reg   <= NEG_THR_RST;
            pos_thr_reg   <= POS_THR_RST;
            coef_reg      <= COEF_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_EMPTY_THR: empty_thr_reg <= pwdata[31:0];
                REG_FULL_THR:  full_lvl_reg  <= pwdata[31:0];
                REG_NEG_THR:   neg_thr_reg   <= pwdata[31:0];
                REG_POS_THR:   pos_thr_reg   <= pwdata[30:0];
                REG_COEF:      coef_reg      <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_EMPTY_THR: prdata = {32'd0, empty_thr_reg};
            REG_FULL_THR:  prdata = {32'd0, full_lvl_reg};
            REG_NEG_THR:   prdata = {{32{neg_thr_reg[31]}}, neg_thr_reg};
            REG_POS_THR:   prdata = {33'd0, pos_thr_reg};
            REG_COEF:      prdata = {16'd0, coef_reg};
            default:       prdata = '0;
        endcase
    end

    fee_fuzz u_fuzz
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .take            (take),
        .residual_energy (residual_energy),
        .energy_change   (energy_change),
        .empty_thr       (empty_thr_reg),
        .full_lvl        (full_lvl_reg),
        .neg_thr         (neg_thr_reg),
        .pos_thr         (pos_thr_reg),
        .memb            (memb)
    );

    fee_rules u_rules
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .memb  (memb),
        .coef  (coef_reg),
        .prod  (prod)
    );

    fee_div u_div
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .prod          (prod),
        .out_valid     (out_valid),
        .energy_budget (energy_budget)
    );

`ifndef ASSERT_OFF
    // Energy memberships never exceed one in total
    a_energy_memb: assert property (@(posedge clk) disable iff (!rst_n)
        memb.valid |-> ({1'b0, memb.emp} + {1'b0, memb.ful}) <= {1'b0, MU_ONE})
        else $error("energy memberships exceed one");

    // Change memberships always total exactly one
    a_change_memb: assert property (@(posedge clk) disable iff (!rst_n)
        memb.valid |-> ({2'b00, memb.neg} + {2'b00, memb.zer} + {2'b00, memb.pos})
            == {2'b00, MU_ONE})
        else $error("change memberships do not total one");

    // Activation sum fits the divisor and matches the zero flag
    a_act_sum: assert property (@(posedge clk) disable iff (!rst_n)
        prod.valid |-> (prod.asum <= MU_ONE) && (prod.zero == (prod.asum == '0)))
        else $error("activation sum out of range");
`endif

endmodule

[bench/fuzzy_energy_budget_estimator_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_energy_budget_estimator_core_test
// Self-checking bench for the fuzzy energy budget estimator. A queued driver
// feeds directed and random requests, a monitor compares each budget with a
// bit-accurate predictor, and register settings change between phases.
// ----------------------------------------------------------------------------
module fuzzy_energy_budget_estimator_core_test
    import fee_pkg::*;
();

    localparam int LATENCY     = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] energy;
        logic [31:0] change;
    } request_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [31:0]         residual_energy;
    logic signed [31:0]  energy_change;
    logic                out_valid;
    logic                out_stall;
    logic [39:0]         energy_budget;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor copy of the registers
    logic [31:0] thr_empty;
    logic [31:0] thr_full;
    logic [31:0] thr_neg;
    logic [30:0] thr_pos;
    logic [47:0] coefs;

    request_t    pending_requests[$];
    logic [39:0] expected_budgets[$];
    int          failures;
    int          budgets_seen;
    int          cycles;
    int          hold_off;
    bit          quiet_driver;
    bit          quiet_monitor;

    fuzzy_energy_budget_estimator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .residual_energy(residual_energy), .energy_change(energy_change),
        .out_valid(out_valid), .out_stall(out_stall),
        .energy_budget(energy_budget),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Q1.16 ramp: (num << 16) / den, zero for an empty span
    function automatic logic [63:0] ramp_value(logic [63:0] num, logic [63:0] den);
        if (den == 0)
            return 0;
        return (num << 16) / den;
    endfunction

    function automatic logic [39:0] predict_budget(logic [31:0] er, logic [31:0] dc);
        logic [63:0] me[2];
        logic [63:0] md[3];
        logic [63:0] r;
        logic [63:0] act;
        logic [63:0] wsum;
        logic [63:0] asum;
        logic signed [63:0] d;
        logic signed [63:0] n;
        logic signed [63:0] p;
        logic [127:0] prod;
        wsum = 0;
        asum = 0;
        d = $signed(dc);
        n = $signed(thr_neg);
        p = {33'd0, thr_pos};
        // energy memberships
        if (er < thr_empty)
        begin
            me[0] = 65536;
            me[1] = 0;
        end
        else if (er < thr_full)
        begin
            me[0] = ramp_value(thr_full - er, thr_full - thr_empty);
            me[1] = ramp_value(er - thr_empty, thr_full - thr_empty);
        end
        else
        begin
            me[0] = 0;
            me[1] = 65536;
        end
        // change memberships
        md[0] = 0;
        md[1] = 0;
        md[2] = 0;
        if (d < n)
            md[0] = 65536;
        else if (d < 0)
        begin
            r = ramp_value(-d, -n);
            md[0] = r;
            md[1] = 65536 - r;
        end
        else if (d < p)
        begin
            r = ramp_value(d, p);
            md[1] = 65536 - r;
            md[2] = r;
        end
        else
            md[2] = 65536;
        // rule activations and weighted sum
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 3; j++)
            begin
                act = (me[i] * md[j]) >> 16;
                wsum += act * coefs[8*(i*3+j) +: 8];
                asum += act;
            end
        if (asum == 0)
            return 0;
        prod = wsum * er;
        return 40'(prod / asum);
    endfunction

    // Driver: offer queued requests, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            residual_energy <= '0;
            energy_change <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_budgets.push_back(predict_budget(residual_energy, energy_change));
                void'(pending_requests.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_requests.size() > (in_valid && !in_stall ? 0 : 0) &&
                    (quiet_driver || $urandom_range(99) >= 35))
                begin
                    in_valid <= 1'b1;
                    residual_energy <= pending_requests[0].energy;
                    energy_change <= pending_requests[0].change;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted budget with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                budgets_seen++;
                if (expected_budgets.size() == 0)
                begin
                    $error("energy_budget: none expected, actual %0d", energy_budget);
                    failures++;
                end
                else
                begin
                    if (energy_budget !== expected_budgets[0])
                    begin
                        $error("energy_budget: expected %0d actual %0d",
                               expected_budgets[0], energy_budget);
                        failures++;
                    end
                    void'(expected_budgets.pop_front());
                end
            end
            if (hold_off > 0)
                out_stall <= 1'b1;
            else
                out_stall <= !quiet_monitor && ($urandom_range(99) < 35);
        end
    end

    // Count down the receiver hold-off
    always @(posedge clk)
    begin
        if (rst_n && hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_register(fee_reg_t index, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * index);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_EMPTY_THR: thr_empty = value[31:0];
            REG_FULL_THR:  thr_full = value[31:0];
            REG_NEG_THR:   thr_neg = value[31:0];
            REG_POS_THR:   thr_pos = value[30:0];
            REG_COEF:      coefs = value[47:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        while (pending_requests.size() != 0 || in_valid || expected_budgets.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic add_request(logic [31:0] er, logic [31:0] dc);
        request_t req;
        req.energy = er;
        req.change = dc;
        pending_requests.push_back(req);
    endtask

    // energy near the thresholds, or anywhere
    function automatic logic [31:0] pick_energy();
        case ($urandom_range(3))
            0: return thr_empty + $urandom_range(200) - 100;
            1: return thr_full + $urandom_range(200) - 100;
            2: return thr_empty + $urandom_range(thr_full - thr_empty);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_change();
        case ($urandom_range(3))
            0: return $signed(thr_neg) - $signed($urandom_range(4)) +
                      $signed($urandom_range(70000));
            1: return {1'b0, thr_pos} - $urandom_range(70000);
            2: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            add_request(pick_energy(), pick_change());
        drain_pipeline();
    endtask

    initial
    begin
        failures = 0;
        budgets_seen = 0;
        cycles = 0;
        hold_off = 0;
        quiet_driver = 0;
        quiet_monitor = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        thr_empty = EMPTY_THR_RST;
        thr_full = FULL_THR_RST;
        thr_neg = NEG_THR_RST;
        thr_pos = POS_THR_RST;
        coefs = COEF_RST;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and ramp regions on reset settings
        add_request(32'h0, 32'h0);
        add_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_request(32'hFFFF_FFFF, 32'h8000_0000);
        add_request(32'h0001_8000, 32'hFFFF_8000);
        add_request(32'h0001_8000, 32'h0000_8000);
        add_request(32'h0001_0000, 32'hFFFF_0000);
        add_request(32'h0002_0000, 32'h0001_0000);
        add_request(32'h0000_FFFF, 32'hFFFF_FFFF);
        add_request(32'h0001_0001, 32'h0000_0001);
        drain_pipeline();

        // thresholds out of order, nonnegative negative and zero positive thresholds
        write_register(REG_EMPTY_THR, 64'h0003_0000);
        write_register(REG_FULL_THR, 64'h0001_0000);
        write_register(REG_NEG_THR, 64'h0000_0000);
        write_register(REG_POS_THR, 64'h0);
        write_register(REG_COEF, 64'hFFFF_FFFF_FFFF);
        add_request(32'h0002_FFFF, 32'hFFFF_FFFF);
        add_request(32'h0003_0000, 32'h0000_0000);
        add_request(32'h0, 32'h8000_0000);
        add_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        drain_pipeline();

        // zero weighted sum: zero coefficients, tiny memberships truncate away
        write_register(REG_EMPTY_THR, 64'h0);
        write_register(REG_FULL_THR, 64'hFFFF_FFFF);
        write_register(REG_NEG_THR, 64'h8000_0000);
        write_register(REG_POS_THR, 64'h7FFF_FFFF);
        write_register(REG_COEF, 64'h0);
        add_request(32'h0000_0001, 32'h7FFF_FFFE);
        add_request(32'hFFFF_FFFE, 32'h7FFF_FFFE);
        add_request(32'h8000_0000, 32'h0);
        drain_pipeline();

        // long receiver hold-off while the sender keeps offering
        write_register(REG_COEF, 64'h0605_0403_0201);
        write_register(REG_FULL_THR, 64'h0002_0000);
        write_register(REG_NEG_THR, 64'hFFFF_0000);
        write_register(REG_POS_THR, 64'h0001_0000);
        quiet_driver = 1;
        for (int i = 0; i < 150; i++)
            add_request(pick_energy(), pick_change());
        hold_off = 300;
        drain_pipeline();
        quiet_driver = 0;

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_register(REG_EMPTY_THR, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000));
            write_register(REG_FULL_THR, $urandom_range(3) == 0 ? $urandom : $urandom_range(400000));
            write_register(REG_NEG_THR, ph == 5 ? 64'($urandom_range(5)) :
                           64'(-$signed({1'b0, $urandom_range(1 << 20)}) - 1));
            write_register(REG_POS_THR, ph == 4 ? 64'h0 : 64'($urandom_range(1 << 20)));
            write_register(REG_COEF, {$urandom, $urandom});
            quiet_driver = (ph == 2);
            quiet_monitor = (ph == 2);
            random_phase(210);
        end
        quiet_driver = 0;
        quiet_monitor = 0;

        $display("Checked %0d budgets over directed corners, a stall flood and six settings",
                 budgets_seen);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[files.f]
hdl/fee_pkg.sv
hdl/fee_fuzz.sv
hdl/fee_rules.sv
hdl/fee_div.sv
hdl/fuzzy_energy_budget_estimator_core.sv
bench/fuzzy_energy_budget_estimator_core_test.sv
